// ----- src/tlwo_pkg.sv -----
// shared types and constants for the text line wrap offset finder
package tlwo_pkg;

	localparam int LINE_W = 17;
	localparam int OFFSET_W = 32;
	localparam int COL_W = 9;
	localparam int TDATA_W = 56;

	localparam logic [COL_W-1:0] TAB_STOP = 9'd8;
	localparam logic [LINE_W-1:0] MAX_LINES = 17'd65536;
	localparam logic [7:0] COLS_RESET = 8'd60;
	localparam logic [7:0] COLS_MIN = 8'd3;

	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	typedef struct packed {
		logic kind;
		logic [LINE_W-1:0] line;
		logic [OFFSET_W-1:0] offset;
		logic last;
	} result_t;

	// up to two records produced by one byte, rec0 goes out first
	typedef struct packed {
		logic [1:0] num;
		result_t rec0;
		result_t rec1;
	} push_t;

endpackage

// ----- src/tlwo_step.sv -----
// input register, line state and per-byte wrap decision
module tlwo_step (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [7:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	input logic in_final,
	input logic [1:0] q_count,
	output tlwo_pkg::push_t push
);
	import tlwo_pkg::*;

	logic [7:0] cpl_q;
	logic [COL_W-1:0] col_q;
	logic [LINE_W-1:0] lines_q;
	logic [OFFSET_W-1:0] pos_q;
	logic pend_q;
	logic [OFFSET_W-1:0] lpos_q;
	logic lim_q;

	logic v_s1;
	logic [7:0] byte_s1;
	logic final_s1;

	logic [7:0] width;
	logic [COL_W-1:0] col_a, col_n;
	logic [OFFSET_W-1:0] pos_inc, end_start, lpos_n;
	logic end_l, may_rep, lead_wrap, pend_n, hit_lim, report, fire;
	logic [LINE_W-1:0] line_inc, lines_a;
	logic [1:0] n_res;
	logic [2:0] room_sum;
	result_t start_rec, count_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpl_q <= COLS_RESET;
		end else if (cfg_wen) begin
			cpl_q <= cfg_wdata;
		end
	end

	always_comb begin
		width = (cpl_q < COLS_MIN) ? COLS_MIN : cpl_q;
		pos_inc = pos_q + 32'd1;
		col_a = col_q;
		end_l = 1'b0;
		end_start = pos_inc;
		may_rep = 1'b1;
		lead_wrap = 1'b0;
		pend_n = pend_q;
		lpos_n = lpos_q;
		if (!lim_q) begin
			if (pend_q) begin
				// trail byte completes the wide character whatever its value
				pend_n = 1'b0;
				col_a = col_q + 9'd2;
				if (col_a >= {1'b0, width}) begin
					end_l = 1'b1;
					end_start = lpos_q;
					lead_wrap = 1'b1;
				end
			end else if (byte_s1 == CHAR_CR) begin
				col_a = col_q;
			end else if (byte_s1 == CHAR_TAB) begin
				col_a = col_q - (col_q % TAB_STOP) + TAB_STOP;
				if (col_a >= {1'b0, width}) begin
					end_l = 1'b1;
					may_rep = !final_s1;
				end
			end else if (byte_s1[7]) begin
				if (final_s1) begin
					col_a = col_q + 9'd2;
					if (col_a >= {1'b0, width}) begin
						end_l = 1'b1;
						end_start = pos_q;
					end
				end else begin
					pend_n = 1'b1;
					lpos_n = pos_q;
				end
			end else begin
				col_a = col_q + 9'd1;
				if (col_a >= {1'b0, width} || byte_s1 == CHAR_LF) begin
					end_l = 1'b1;
					may_rep = !final_s1;
				end
			end
		end
		line_inc = lines_q + 17'd1;
		hit_lim = end_l && (line_inc >= MAX_LINES);
		report = end_l && !hit_lim && may_rep;
		lines_a = end_l ? line_inc : lines_q;
		if (end_l) begin
			col_n = (lead_wrap && !hit_lim) ? 9'd2 : 9'd0;
		end else begin
			col_n = col_a;
		end
	end

	always_comb begin
		n_res = {1'b0, report} + {1'b0, final_s1};
		room_sum = {1'b0, q_count} + {1'b0, n_res};
		fire = v_s1 && (room_sum <= 3'd2);
		in_ready = !v_s1 || fire;

		start_rec.kind = KIND_START;
		start_rec.line = line_inc;
		start_rec.offset = end_start;
		start_rec.last = !final_s1;
		count_rec.kind = KIND_COUNT;
		count_rec.line = lines_a;
		count_rec.offset = '0;
		count_rec.last = 1'b1;

		push.num = fire ? n_res : 2'd0;
		push.rec0 = report ? start_rec : count_rec;
		push.rec1 = count_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			final_s1 <= in_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			lines_q <= '0;
			pos_q <= '0;
			pend_q <= 1'b0;
			lpos_q <= '0;
			lim_q <= 1'b0;
		end else if (fire) begin
			if (final_s1) begin
				// end of file: start over for the next one
				col_q <= '0;
				lines_q <= '0;
				pos_q <= '0;
				pend_q <= 1'b0;
				lpos_q <= '0;
				lim_q <= 1'b0;
			end else begin
				col_q <= col_n;
				lines_q <= lines_a;
				pos_q <= pos_inc;
				pend_q <= pend_n;
				lpos_q <= lpos_n;
				lim_q <= lim_q | hit_lim;
			end
		end
	end

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && final_s1) |=> (col_q == '0 && lines_q == '0 && !pend_q && !lim_q))
		else $error("state not cleared after final byte");

	a_limit_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(lim_q && !(fire && final_s1)) |=> lim_q)
		else $error("line limit dropped before final byte");

	a_no_push_without_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != 2'd0) |-> ({1'b0, q_count} + {1'b0, push.num} <= 3'd2))
		else $error("result queue overflow");

	a_pos_frozen_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(pos_q))
		else $error("byte offset moved without a byte");

endmodule

// ----- src/tlwo_result_queue.sv -----
// two-entry result queue feeding the output stream
module tlwo_result_queue (
	input logic clk,
	input logic arst_n,
	input tlwo_pkg::push_t push,
	output logic [1:0] q_count,
	output logic out_valid,
	input logic out_ready,
	output tlwo_pkg::result_t out_rec
);
	import tlwo_pkg::*;

	result_t e0_q, e1_q, e0_n, e1_n;
	logic [1:0] cnt_q, base, cnt_n;
	logic pop;

	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_rec = e0_q;
	assign q_count = cnt_q;

	always_comb begin
		base = cnt_q - {1'b0, pop};
		e0_n = pop ? e1_q : e0_q;
		e1_n = e1_q;
		case (base)
			2'd0: begin
				if (push.num != 2'd0) e0_n = push.rec0;
				if (push.num == 2'd2) e1_n = push.rec1;
			end
			2'd1: begin
				if (push.num != 2'd0) e1_n = push.rec0;
			end
			default: begin
				e1_n = e1_q;
			end
		endcase
		cnt_n = base + push.num;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= e0_n;
		e1_q <= e1_n;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("queue count out of range");

	a_count_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_rec.kind == KIND_COUNT) |-> out_rec.last)
		else $error("count record not marked last");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q == 2'd2) |=> out_valid)
		else $error("second queued record lost");

endmodule

// ----- src/text_line_wrap_offsets_core.sv -----
// top level of the text line wrap offset finder
// Takes one text byte per cycle on the input stream (tlast marks the final byte of a
// file) and reports the byte offset where each display line starts; on the final byte
// it adds a record with the total line count. A byte is accepted every cycle as long as
// the two-entry output queue can hold its records, so the rate is one byte per cycle
// while results are taken promptly, except that a final byte that produces two records
// can hold the input while the queue makes room. The results of an input byte pass
// through the input register, then the queue register, before they reach the output.
// columns_per_line is written through cfg_wen/cfg_wdata, by the user only while the
// block is idle, which the block does not enforce; it takes effect on the next byte.
module text_line_wrap_offsets_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [7:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // text_byte
	input logic s_tlast, // final_byte
	output logic m_tvalid,
	input logic m_tready,
	output logic [tlwo_pkg::TDATA_W-1:0] m_tdata, // line_number[16:0], start_offset[48:17]
	output logic m_tuser, // record_kind
	output logic m_tlast // last_of_run
);
	import tlwo_pkg::*;

	push_t push;
	logic [1:0] q_count;
	result_t out_rec;

	tlwo_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte(s_tdata),
		.in_final(s_tlast),
		.q_count(q_count),
		.push(push)
	);

	tlwo_result_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.q_count(q_count),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_rec(out_rec)
	);

	assign m_tdata = {7'd0, out_rec.offset, out_rec.line};
	assign m_tuser = out_rec.kind;
	assign m_tlast = out_rec.last;

endmodule
